/* rtl/cdt_pkg.sv */
`default_nettype none

package cdt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int GROUP_SIZE  = 8;
  localparam int GROUP_W     = $clog2(GROUP_SIZE);
  localparam int NUM_STAGES  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int STAGE_W     = $clog2(NUM_STAGES);
  localparam int ENTRY_W     = STAGE_W + GROUP_W;

  // Field widths
  localparam int VALUE_W  = 64;
  localparam int INDEX_W  = 8;
  localparam int LAST_W   = 8;
  localparam int SAMPLE_W = 9;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LAST_INDEX = 1'b0;  // register select bit paddr[2]
  localparam logic [LAST_W-1:0] LAST_INDEX_RST = '1;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_DRAW = 1'b1
  } func_e;

  // One request as it travels down the scan pipeline
  typedef struct packed {
    func_e               func;
    logic [INDEX_W-1:0]  entry_index;
    logic [VALUE_W-1:0]  entry_value;
    logic [VALUE_W-1:0]  uniform_value;
    logic                sign_random;
    logic                found;
    logic [LAST_W-1:0]   chosen;
  } pipe_t;

  // Clamp the programmed range to the table
  function automatic logic [LAST_W-1:0] eff_last(input logic [LAST_W-1:0] last);
    logic [LAST_W-1:0] res;
    res = last;
    if (32'(last) > TABLE_DEPTH - 1) begin
      res = LAST_W'(TABLE_DEPTH - 1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/cdt_gaussian_sampler.sv */
`default_nettype none

// Discrete Gaussian sampler over a cumulative distribution table of 256
// 64-bit entries. A load request (func 0) writes one entry; a draw request
// (func 1) returns the smallest index at or below last_index whose entry is
// at least uniform_value (last_index when none is), negated when sign_random
// is set and the index is nonzero. The table is split into 32 slices of eight
// entries, one pipeline stage each, so every draw compares all entries in use
// in constant time. One request enters per cycle while the output does not stall;
// a draw request is captured at acceptance, then passes 32 slice stages and
// an output register before its result appears. Loads travel the same pipeline
// and write their entry when they pass its slice, so requests take effect
// strictly in order. Loads produce no result. Entries must be loaded before
// a draw reads them. A stall on the output freezes the whole pipeline.
module cdt_gaussian_sampler (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Request channel
  input  wire logic                                valid_i,
  output logic                                     stall_o,
  input  wire logic                                func_i,
  input  wire logic [cdt_pkg::INDEX_W-1:0]         entry_index_i,
  input  wire logic [cdt_pkg::VALUE_W-1:0]         entry_value_i,
  input  wire logic [cdt_pkg::VALUE_W-1:0]         uniform_value_i,
  input  wire logic                                sign_random_i,
  // Result channel
  output logic                                     valid_o,
  input  wire logic                                stall_i,
  output logic signed [cdt_pkg::SAMPLE_W-1:0]      sample_value_o,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cdt_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [cdt_pkg::PDATA_W-1:0]         pwdata,
  output logic [cdt_pkg::PDATA_W-1:0]              prdata,
  output logic                                     pready
);

  localparam int NS = cdt_pkg::NUM_STAGES;

  logic [cdt_pkg::LAST_W-1:0] last_index_q;
  logic                       adv;
  cdt_pkg::pipe_t             in_item;
  cdt_pkg::pipe_t             st_q   [NS+1];
  logic                       st_vld_q [NS+1];
  cdt_pkg::pipe_t             st_d   [NS];
  logic                       out_vld_q;
  logic signed [cdt_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [cdt_pkg::SAMPLE_W-1:0] sample_d;
  logic [cdt_pkg::LAST_W-1:0] chosen_fin;
  logic [cdt_pkg::SAMPLE_W-1:0] mag;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cdt_pkg::REG_LAST_INDEX) ?
                  cdt_pkg::PDATA_W'(last_index_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= cdt_pkg::LAST_INDEX_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == cdt_pkg::REG_LAST_INDEX)) begin
      last_index_q <= pwdata[cdt_pkg::LAST_W-1:0];
    end
  end

  // Hold the whole pipeline while a result waits
  assign stall_o = out_vld_q && stall_i;
  assign adv     = !stall_o;

  // Pack the incoming request
  always_comb begin
    in_item               = '0;
    in_item.func          = cdt_pkg::func_e'(func_i);
    in_item.entry_index   = entry_index_i;
    in_item.entry_value   = entry_value_i;
    in_item.uniform_value = uniform_value_i;
    in_item.sign_random   = sign_random_i;
    in_item.found         = 1'b0;
    in_item.chosen        = '0;
  end

  // Scan slices
  for (genvar s = 0; s < NS; s++) begin : g_stage
    cdt_stage u_stage (
      .clk_i        (clk_i),
      .stage_idx_i  (cdt_pkg::STAGE_W'(s)),
      .last_index_i (last_index_q),
      .adv_i        (adv),
      .vld_i        (st_vld_q[s]),
      .item_i       (st_q[s]),
      .item_o       (st_d[s])
    );
  end

  // Resolve the default index and apply the sign
  always_comb begin
    chosen_fin = st_q[NS].found ? st_q[NS].chosen : cdt_pkg::eff_last(last_index_q);
    mag        = cdt_pkg::SAMPLE_W'(chosen_fin);
    if (st_q[NS].sign_random && (chosen_fin != '0)) begin
      sample_d = cdt_pkg::SAMPLE_W'(cdt_pkg::SAMPLE_W'(0) - mag);
    end else begin
      sample_d = mag;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) begin
        st_vld_q[s] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      st_vld_q[0] <= valid_i;
      for (int s = 0; s < NS; s++) begin
        st_vld_q[s+1] <= st_vld_q[s];
      end
      out_vld_q <= st_vld_q[NS] && (st_q[NS].func == cdt_pkg::FUNC_DRAW);
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= in_item;
      for (int s = 0; s < NS; s++) begin
        st_q[s+1] <= st_d[s];
      end
      sample_q <= sample_d;
    end
  end

  assign valid_o        = out_vld_q;
  assign sample_value_o = sample_q;

  // A draw leaving the last slice always becomes a result
  a_draw_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && st_vld_q[NS] && (st_q[NS].func == cdt_pkg::FUNC_DRAW)) |=> valid_o)
    else $error("draw request lost at output");

  // Loads and bubbles never create a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !(st_vld_q[NS] && (st_q[NS].func == cdt_pkg::FUNC_DRAW))) |=> !valid_o)
    else $error("result without draw request");

  // A stall freezes the pipeline valid bits
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> ($stable(st_vld_q[0]) && $stable(st_vld_q[NS])))
    else $error("pipeline moved during stall");

  // A matched index lies inside the scanned range
  a_match_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_vld_q[NS] && (st_q[NS].func == cdt_pkg::FUNC_DRAW) && st_q[NS].found) |->
    (st_q[NS].chosen <= cdt_pkg::eff_last(last_index_q)))
    else $error("match beyond last index");

  // Magnitude never reaches the most negative code
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (sample_value_o != $signed({1'b1, {(cdt_pkg::SAMPLE_W-1){1'b0}}})))
    else $error("sample out of range");

endmodule

`default_nettype wire

/* rtl/cdt_stage.sv */
`default_nettype none

// One slice of the table: holds GROUP_SIZE entries, writes them when a load
// request passes, and extends the first-match search for a draw request.
module cdt_stage (
  input  wire logic                             clk_i,
  input  wire logic [cdt_pkg::STAGE_W-1:0]      stage_idx_i,
  input  wire logic [cdt_pkg::LAST_W-1:0]       last_index_i,
  input  wire logic                             adv_i,
  input  wire logic                             vld_i,
  input  wire cdt_pkg::pipe_t                   item_i,
  output cdt_pkg::pipe_t                        item_o
);

  logic [cdt_pkg::VALUE_W-1:0] ent_q [cdt_pkg::GROUP_SIZE];
  logic [cdt_pkg::GROUP_SIZE-1:0] hit;
  logic [cdt_pkg::GROUP_SIZE-1:0] wr_en;

  // Compare every entry of the slice and decode the load target
  always_comb begin
    logic [cdt_pkg::ENTRY_W-1:0] k;
    for (int j = 0; j < cdt_pkg::GROUP_SIZE; j++) begin
      k = {stage_idx_i, cdt_pkg::GROUP_W'(j)};
      hit[j] = (32'(k) < cdt_pkg::TABLE_DEPTH) && (32'(k) <= 32'(last_index_i)) &&
               (ent_q[j] >= item_i.uniform_value);
      wr_en[j] = adv_i && vld_i && (item_i.func == cdt_pkg::FUNC_LOAD) &&
                 (32'(k) < cdt_pkg::TABLE_DEPTH) &&
                 (32'(item_i.entry_index) == 32'(k));
    end
  end

  // Take the lowest matching entry unless an earlier slice already matched
  always_comb begin
    logic [cdt_pkg::ENTRY_W-1:0] k;
    item_o = item_i;
    for (int j = 0; j < cdt_pkg::GROUP_SIZE; j++) begin
      k = {stage_idx_i, cdt_pkg::GROUP_W'(j)};
      if (hit[j] && !item_o.found) begin
        item_o.found  = 1'b1;
        item_o.chosen = cdt_pkg::LAST_W'(k);
      end
    end
  end

  // Write table entries in request order
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < cdt_pkg::GROUP_SIZE; j++) begin
      if (wr_en[j]) begin
        ent_q[j] <= item_i.entry_value;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;

  localparam int CLK_HALF     = 5;
  localparam int DRAIN_CYCLES = 48;      // pipeline is 34 deep; allow margin
  localparam int CYCLE_LIMIT  = 300000;
  localparam logic [cdt_pkg::PADDR_W-1:0] LAST_INDEX_ADDR = {cdt_pkg::REG_LAST_INDEX, 2'b00};

  // One request as the sender sees it
  typedef struct {
    cdt_pkg::func_e func;
    logic [7:0]     idx;
    logic [63:0]    val;
    logic [63:0]    uni;
    logic           sgn;
  } request_t;

  // Shadow of the sampler: table copy, range register, and samples in flight
  class cdt_shadow;
    logic [63:0]       cdf_copy [cdt_pkg::TABLE_DEPTH];
    logic [7:0]        range_top;
    logic signed [8:0] pending_samples [$];
    int                errors;
    int                draws_checked;

    function new();
      range_top     = '1;
      errors        = 0;
      draws_checked = 0;
    endfunction

    function void set_range(input logic [7:0] top);
      range_top = top;
    endfunction

    function int scan_top();
      int top;
      top = range_top;
      if (top > cdt_pkg::TABLE_DEPTH - 1) top = cdt_pkg::TABLE_DEPTH - 1;
      return top;
    endfunction

    // First entry at or above the uniform word, else the top of the range
    function logic signed [8:0] predict_sample(input logic [63:0] uni, input logic sgn);
      int                top;
      int                chosen;
      bit                found;
      logic signed [8:0] mag;
      top    = scan_top();
      chosen = top;
      found  = 0;
      for (int k = 0; k <= top; k++) begin
        if (!found && cdf_copy[k] >= uni) begin
          chosen = k;
          found  = 1;
        end
      end
      mag = 9'(chosen);
      if (sgn && chosen != 0) mag = -mag;
      return mag;
    endfunction

    function void note_request(input request_t r);
      if (r.func == cdt_pkg::FUNC_LOAD) begin
        if (int'(r.idx) < cdt_pkg::TABLE_DEPTH) cdf_copy[r.idx] = r.val;
      end else begin
        pending_samples.push_back(predict_sample(r.uni, r.sgn));
      end
    endfunction

    function void check_sample(input logic signed [8:0] got);
      logic signed [8:0] want;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample %0d with no draw outstanding", $time, got);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      draws_checked++;
      if (got !== want) begin
        $display("%0t: sample mismatch: expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                valid_i = 1'b0;
  logic                                stall_o;
  logic                                func_i = 1'b0;
  logic [cdt_pkg::INDEX_W-1:0]         entry_index_i = '0;
  logic [cdt_pkg::VALUE_W-1:0]         entry_value_i = '0;
  logic [cdt_pkg::VALUE_W-1:0]         uniform_value_i = '0;
  logic                                sign_random_i = 1'b0;
  logic                                valid_o;
  logic                                stall_i = 1'b0;
  logic signed [cdt_pkg::SAMPLE_W-1:0] sample_value_o;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [cdt_pkg::PADDR_W-1:0]         paddr = '0;
  logic [cdt_pkg::PDATA_W-1:0]         pwdata = '0;
  logic [cdt_pkg::PDATA_W-1:0]         prdata;
  logic                                pready;

  int        send_idle_pct = 28;
  int        recv_idle_pct = 61;
  int        cycle_count = 0;
  int        loads_sent = 0;
  int        draws_sent = 0;
  cdt_shadow sb = new();

  cdt_gaussian_sampler uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .func_i          (func_i),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i),
    .uniform_value_i (uniform_value_i),
    .sign_random_i   (sign_random_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .sample_value_o  (sample_value_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d samples outstanding", $time,
               sb.pending_samples.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stall at random, check every accepted sample
  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) sb.check_sample(sample_value_o);
  end

  // Drive one request; called and returns at a falling edge
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i         <= 1'b1;
    func_i          <= r.func;
    entry_index_i   <= r.idx;
    entry_value_i   <= r.val;
    uniform_value_i <= r.uni;
    sign_random_i   <= r.sgn;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic load_entry(input logic [7:0] k, input logic [63:0] v);
    request_t r;
    r.func = cdt_pkg::FUNC_LOAD;
    r.idx  = k;
    r.val  = v;
    r.uni  = {$urandom, $urandom};
    r.sgn  = 1'($urandom_range(1));
    loads_sent++;
    send_request(r);
  endtask

  task automatic request_draw(input logic [63:0] u, input logic s);
    request_t r;
    r.func = cdt_pkg::FUNC_DRAW;
    r.idx  = 8'($urandom);
    r.val  = {$urandom, $urandom};
    r.uni  = u;
    r.sgn  = s;
    draws_sent++;
    send_request(r);
  endtask

  // Write last_index through the two-phase register port
  task automatic write_last_index(input logic [7:0] top);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LAST_INDEX_ADDR;
    pwdata  <= {24'h0, top};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_range(top);
  endtask

  // Drop valid, wait out all samples and any loads still in the pipe
  task automatic drain_pipeline();
    valid_i <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Load a rising table over 0..top, leaving headroom above the last entry
  task automatic fill_table(input int top);
    logic [63:0] step;
    step = 64'hFFFF_FFFF_FFFF_FFFF / 64'(top + 2);
    for (int k = 0; k <= top; k++) begin
      load_entry(8'(k), step * 64'(k + 1) + ({$urandom, $urandom} % (step / 2 + 1)));
    end
  endtask

  // Mostly draws aimed at table boundaries, some stray loads
  task automatic run_mix(input int n, input int load_pct);
    int          top;
    int          k;
    logic [63:0] base;
    logic [63:0] u;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < load_pct) begin
        load_entry(8'($urandom_range(255)), {$urandom, $urandom});
      end else begin
        top  = sb.scan_top();
        k    = $urandom_range(top, 0);
        base = sb.cdf_copy[k];
        case ($urandom_range(9))
          0, 1, 2: u = base;
          3:       u = base + 64'd1;
          4:       u = base - 64'd1;
          5, 6:    u = {$urandom, $urandom};
          7:       u = '0;
          8:       u = '1;
          default: u = sb.cdf_copy[top] + 64'd1;
        endcase
        request_draw(u, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int top;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: small range, boundary values, sign handling, no-match default
    write_last_index(8'd3);
    load_entry(8'd0, 64'h0);
    load_entry(8'd1, 64'h1);
    load_entry(8'd2, 64'h8000_0000_0000_0000);
    load_entry(8'd3, 64'hFFFF_FFFF_FFFF_FFFE);
    load_entry(8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
    request_draw(64'h0, 1'b1);
    request_draw(64'h0, 1'b0);
    request_draw(64'h1, 1'b1);
    request_draw(64'h2, 1'b0);
    request_draw(64'h8000_0000_0000_0000, 1'b1);
    request_draw(64'h8000_0000_0000_0001, 1'b1);
    request_draw(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    request_draw(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    drain_pipeline();

    // Single-entry range: every draw lands on zero
    write_last_index(8'd0);
    request_draw(64'h0, 1'b1);
    request_draw(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    request_draw(64'h1, 1'b0);
    drain_pipeline();

    // Sender idles lightly, receiver heavily
    top = $urandom_range(40, 10);
    write_last_index(8'(top));
    fill_table(top);
    run_mix(50, 25);
    drain_pipeline();

    // Swap idling, full table
    send_idle_pct = 61;
    recv_idle_pct = 28;
    write_last_index(8'd255);
    fill_table(255);
    run_mix(25, 20);
    drain_pipeline();

    // No idling, random range over the full table
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_last_index(8'($urandom_range(254, 1)));
    run_mix(35, 20);
    drain_pipeline();

    $display("Sent %0d loads and %0d draws; checked %0d samples", loads_sent, draws_sent,
             sb.draws_checked);
    $display("Ranges covered: 0, 3, partial, full 255, under three idle patterns");
    if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
